@@ sv/worst_fit_block_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL.
// Each macro expects clk and arst_n in scope.
`ifndef WORST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WFBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define WFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/wfba_pkg.sv @@
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types, codes and microcode table of the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

	localparam int NumBlocksDef = 16;
	localparam int SizeW        = 16;
	localparam int OwnerW       = 8;
	localparam int FragW        = 20;
	localparam int NumW         = 5;
	localparam int ActW         = 2;
	localparam int BidxW        = 4;

	localparam logic [FragW-1:0] FragMax = '1;

	typedef logic [ActW-1:0] action_t;
	localparam action_t ACT_LOAD   = 2'd0;
	localparam action_t ACT_ALLOC  = 2'd1;
	localparam action_t ACT_REPORT = 2'd2;

	typedef enum logic [1:0] {
		ST_DONE,
		ST_NO_FIT,
		ST_BAD_INDEX
	} status_t;

	// jump conditions of the sequencer
	typedef enum logic [1:0] {
		J_NEVER,
		J_ALWAYS,
		J_SKIP,
		J_MORE
	} jcond_t;

	typedef logic [1:0] upc_t;
	localparam upc_t UPC_IDLE   = 2'd0;
	localparam upc_t UPC_SCAN   = 2'd1;
	localparam upc_t UPC_DRAIN  = 2'd2;
	localparam upc_t UPC_FINISH = 2'd3;

	typedef struct packed {
		logic   wait_start;
		logic   rd;
		logic   finish;
		jcond_t cond;
		upc_t   target;
	} ctrl_t;

	typedef struct packed {
		logic skip_scan;
		logic last;
	} seq_cond_t;

	typedef struct packed {
		logic              en;
		logic              left_en;
		logic [SizeW-1:0]  size;
		logic [OwnerW-1:0] owner;
		logic [SizeW-1:0]  left;
	} tbl_wr_t;

	typedef struct packed {
		logic [SizeW-1:0]  size;
		logic [OwnerW-1:0] owner;
		logic [SizeW-1:0]  left;
	} tbl_rd_t;

	// Microcode program: idle/dispatch, scan loop, drain, finish.
	function automatic ctrl_t ucode(input upc_t upc);
		ctrl_t c;
		c = '0;
		unique case (upc)
			UPC_IDLE: begin
				c.wait_start = 1'b1;
				c.cond       = J_SKIP;
				c.target     = UPC_FINISH;
			end
			UPC_SCAN: begin
				c.rd     = 1'b1;
				c.cond   = J_MORE;
				c.target = UPC_SCAN;
			end
			UPC_DRAIN: begin
				c.cond   = J_NEVER;
				c.target = UPC_IDLE;
			end
			UPC_FINISH: begin
				c.finish = 1'b1;
				c.cond   = J_ALWAYS;
				c.target = UPC_IDLE;
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

@@ sv/wfba_useq.sv @@
// ----------------------------------------------------------------------------
// wfba_useq
// Step counter and microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module wfba_useq
	import wfba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  seq_cond_t cond,
	output ctrl_t     ctrl
);

	upc_t upc_q;
	upc_t upc_nxt;
	logic take;

	assign ctrl = ucode(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			J_NEVER:  take = 1'b0;
			J_ALWAYS: take = 1'b1;
			J_SKIP:   take = cond.skip_scan;
			J_MORE:   take = !cond.last;
			default:  take = 1'b0;
		endcase
	end

	always_comb begin
		if (ctrl.wait_start && !start) begin
			upc_nxt = upc_q;
		end else if (take) begin
			upc_nxt = ctrl.target;
		end else begin
			upc_nxt = upc_q + upc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

@@ sv/wfba_table.sv @@
// ----------------------------------------------------------------------------
// wfba_table
// Block table: size, owner and leftover memories with one registered read
// port and one write port; per-entry valid bits make unwritten entries free.
// ----------------------------------------------------------------------------
module wfba_table
	import wfba_pkg::*;
#(
	parameter int NumBlocks = NumBlocksDef,
	localparam int IdxW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1
)(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [IdxW-1:0] rd_addr,
	input  tbl_wr_t         wr,
	input  logic [IdxW-1:0] wr_addr,
	output tbl_rd_t         rd_data
);

	logic [SizeW-1:0]  size_mem  [NumBlocks];
	logic [OwnerW-1:0] owner_mem [NumBlocks];
	logic [SizeW-1:0]  left_mem  [NumBlocks];
	logic [NumBlocks-1:0] valid_q;

	logic [SizeW-1:0]  size_s1;
	logic [OwnerW-1:0] owner_s1;
	logic [SizeW-1:0]  left_s1;
	logic              vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			size_mem[wr_addr]  <= wr.size;
			owner_mem[wr_addr] <= wr.owner;
			if (wr.left_en) begin
				left_mem[wr_addr] <= wr.left;
			end
		end
		if (rd_en) begin
			size_s1  <= size_mem[rd_addr];
			owner_s1 <= owner_mem[rd_addr];
			left_s1  <= left_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	// an entry never written reads as a free block of size zero
	assign rd_data.size  = vld_s1 ? size_s1 : '0;
	assign rd_data.owner = vld_s1 ? owner_s1 : '0;
	assign rd_data.left  = left_s1;

endmodule

@@ sv/wfba_datapath.sv @@
// ----------------------------------------------------------------------------
// wfba_datapath
// Operand latch, scan counter, worst-fit search, fragmentation accumulators,
// table write-back and result registers.
// ----------------------------------------------------------------------------
module wfba_datapath
	import wfba_pkg::*;
#(
	parameter int NumBlocks = NumBlocksDef,
	localparam int IdxW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1,
	localparam int CntW = $clog2(NumBlocks + 1)
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  action_t           action,
	input  logic [BidxW-1:0]  block_index,
	input  logic [SizeW-1:0]  size,
	input  logic [OwnerW-1:0] process_id,
	input  logic [CntW-1:0]   live_n,
	input  ctrl_t             ctrl,
	input  tbl_rd_t           rd_data,
	output seq_cond_t         cond,
	output logic [IdxW-1:0]   rd_addr,
	output tbl_wr_t           wr,
	output logic [IdxW-1:0]   wr_addr,
	output logic              done,
	output logic [NumW-1:0]   block_number,
	output logic [SizeW-1:0]  leftover,
	output logic [FragW-1:0]  slack_total,
	output logic [FragW-1:0]  free_total,
	output logic [1:0]        status
);

	action_t           action_q;
	logic [BidxW-1:0]  bidx_q;
	logic [SizeW-1:0]  req_q;
	logic [OwnerW-1:0] pid_q;

	logic [IdxW-1:0]   idx_q;
	logic              rd_vld_s1;
	logic [IdxW-1:0]   rd_idx_s1;

	logic              found_q;
	logic [IdxW-1:0]   pick_q;
	logic [SizeW-1:0]  best_q;
	logic [SizeW-1:0]  best_size_q;
	logic [FragW-1:0]  inner_q;
	logic [FragW-1:0]  outer_q;

	logic              done_q;
	logic [NumW-1:0]   bnum_q;
	logic [SizeW-1:0]  left_q;
	logic [FragW-1:0]  ifrag_q;
	logic [FragW-1:0]  efrag_q;
	status_t           status_q;

	logic              fits;
	logic [SizeW-1:0]  left_w;
	logic              take_pick;
	logic [FragW:0]    inner_sum;
	logic [FragW:0]    outer_sum;
	logic              load_ok;

	// dispatch decision on the raw inputs, while idle
	assign cond.skip_scan = !(action == ACT_ALLOC || action == ACT_REPORT) ||
		(live_n == '0) || (action == ACT_ALLOC && process_id == '0);
	assign cond.last      = ((CntW'(idx_q) + CntW'(1)) == live_n);

	assign rd_addr = idx_q;

	assign fits      = (rd_data.owner == '0) && (rd_data.size >= req_q);
	assign left_w    = rd_data.size - req_q;
	assign take_pick = rd_vld_s1 && (action_q == ACT_ALLOC) && fits &&
		(!found_q || (left_w > best_q));

	assign inner_sum = {1'b0, inner_q} + (FragW + 1)'(rd_data.left);
	assign outer_sum = {1'b0, outer_q} + (FragW + 1)'(rd_data.size);

	assign load_ok = (32'(bidx_q) < 32'(live_n));

	// write-back at the finish step
	always_comb begin
		wr         = '0;
		wr_addr    = pick_q;
		if (ctrl.finish) begin
			if (action_q == ACT_LOAD && load_ok) begin
				wr.en   = 1'b1;
				wr.size = req_q;
				wr_addr = IdxW'(bidx_q);
			end else if (action_q == ACT_ALLOC && found_q) begin
				wr.en      = 1'b1;
				wr.left_en = 1'b1;
				wr.size    = best_size_q;
				wr.owner   = pid_q;
				wr.left    = best_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			bidx_q   <= block_index;
			req_q    <= size;
			pid_q    <= process_id;
			idx_q    <= '0;
			inner_q  <= '0;
			outer_q  <= '0;
		end else begin
			if (ctrl.rd) begin
				idx_q <= idx_q + IdxW'(1);
			end
			if (rd_vld_s1 && action_q == ACT_REPORT) begin
				if (rd_data.owner != '0) begin
					inner_q <= inner_sum[FragW] ? FragMax : inner_sum[FragW-1:0];
				end else begin
					outer_q <= outer_sum[FragW] ? FragMax : outer_sum[FragW-1:0];
				end
			end
		end
		rd_idx_s1 <= idx_q;
		if (take_pick) begin
			pick_q      <= rd_idx_s1;
			best_q      <= left_w;
			best_size_q <= rd_data.size;
		end
		if (ctrl.finish) begin
			bnum_q   <= '0;
			left_q   <= '0;
			ifrag_q  <= '0;
			efrag_q  <= '0;
			status_q <= ST_DONE;
			case (action_q)
				ACT_LOAD: begin
					if (!load_ok) begin
						status_q <= ST_BAD_INDEX;
					end
				end
				ACT_ALLOC: begin
					if (found_q) begin
						bnum_q <= NumW'(pick_q) + NumW'(1);
						left_q <= best_q;
					end else begin
						status_q <= ST_NO_FIT;
					end
				end
				ACT_REPORT: begin
					ifrag_q <= inner_q;
					efrag_q <= outer_q;
				end
				default: status_q <= ST_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= ctrl.rd;
			done_q    <= ctrl.finish;
			if (accept) begin
				found_q <= 1'b0;
			end else if (take_pick) begin
				found_q <= 1'b1;
			end
		end
	end

	assign done          = done_q;
	assign block_number  = bnum_q;
	assign leftover      = left_q;
	assign slack_total   = ifrag_q;
	assign free_total    = efrag_q;
	assign status        = status_q;

endmodule

@@ sv/worst_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// worst_fit_block_allocator
// Fixed-partition worst-fit allocator run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Load items and unknown
// actions skip the table scan; allocate and report items read one table entry
// per cycle through the single table read port, one entry for each of the n
// active blocks. An allocate with process number zero, or any item while no
// block is active, also skips the scan. The result shows on the output ports
// for exactly one cycle with done high; there is no backpressure, so capture
// it in that cycle. busy is already low in that cycle, and the next item may
// start alongside it. Write active_blocks only while busy is low and no result
// is pending.
module worst_fit_block_allocator
	import wfba_pkg::*;
#(
	parameter int NUM_BLOCKS = NumBlocksDef
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ActW-1:0]   action,
	input  logic [BidxW-1:0]  block_index,
	input  logic [SizeW-1:0]  size,
	input  logic [OwnerW-1:0] process_id,
	input  logic              active_blocks_we,
	input  logic [NumW-1:0]   active_blocks_wdata,
	output logic              done,
	output logic [NumW-1:0]   block_number,
	output logic [SizeW-1:0]  leftover,
	output logic [FragW-1:0]  slack_total,
	output logic [FragW-1:0]  free_total,
	output logic [1:0]        status
);

	localparam int IdxW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CntW = $clog2(NUM_BLOCKS + 1);

	logic [NumW-1:0] active_q;
	logic [CntW-1:0] live_n;
	logic            accept;
	ctrl_t           ctrl;
	seq_cond_t       cond;
	tbl_wr_t         wr;
	tbl_rd_t         rd_data;
	logic [IdxW-1:0] rd_addr;
	logic [IdxW-1:0] wr_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= NumW'(16);
		end else if (active_blocks_we) begin
			active_q <= active_blocks_wdata;
		end
	end

	// clamp the active count to the table depth
	always_comb begin
		if (32'(active_q) > NUM_BLOCKS) begin
			live_n = CntW'(NUM_BLOCKS);
		end else begin
			live_n = CntW'(active_q);
		end
	end

	assign busy   = !ctrl.wait_start;
	assign accept = start && ctrl.wait_start;

	wfba_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cond   (cond),
		.ctrl   (ctrl)
	);

	wfba_table #(
		.NumBlocks (NUM_BLOCKS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ctrl.rd),
		.rd_addr (rd_addr),
		.wr      (wr),
		.wr_addr (wr_addr),
		.rd_data (rd_data)
	);

	wfba_datapath #(
		.NumBlocks (NUM_BLOCKS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.action        (action),
		.block_index   (block_index),
		.size          (size),
		.process_id    (process_id),
		.live_n        (live_n),
		.ctrl          (ctrl),
		.rd_data       (rd_data),
		.cond          (cond),
		.rd_addr       (rd_addr),
		.wr            (wr),
		.wr_addr       (wr_addr),
		.done          (done),
		.block_number  (block_number),
		.leftover      (leftover),
		.slack_total   (slack_total),
		.free_total    (free_total),
		.status        (status)
	);

`include "worst_fit_block_allocator_assert.svh"

	`WFBA_ASSERT_NEXT(a_finish_gives_done, ctrl.finish, done, "finish step without result strobe")
	`WFBA_ASSERT_NEXT(a_accept_goes_busy, accept && !cond.skip_scan, busy, "scan not started")
	`WFBA_ASSERT_NOW(a_scan_in_range, ctrl.rd, CntW'(rd_addr) < live_n, "scan past active blocks")
	`WFBA_ASSERT_NOW(a_grant_is_done, done && block_number != '0, status == ST_DONE, "grant with error status")

endmodule
